// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent implication check under active-low reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication check under active-low reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/rse_pkg.sv -----
// Types, constants and functions of the row softmax engine.
package rse_pkg;
    localparam int STORE_DEPTH = 64;
    localparam int MAX_ROW_DEF = 64;
    localparam int IDX_W = 6;
    localparam int SUM_W = 23;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    typedef struct packed {
        logic signed [15:0] logit;
        logic               row_end;
    } rse_in_t;

    typedef struct packed {
        logic [15:0]      prob;
        logic [IDX_W-1:0] elem_index;
        logic             last_out;
        logic             truncated;
    } rse_out_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_EXP_RD,
        ST_EXP_WAIT,
        ST_EXP_ACC,
        ST_NRM_RD,
        ST_NRM_DIV,
        ST_NRM_OUT
    } rse_state_t;

    function automatic logic [16:0] pow2_tab(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:  v = 17'd65536;
            5'd1:  v = 17'd62757;
            5'd2:  v = 17'd60097;
            5'd3:  v = 17'd57549;
            5'd4:  v = 17'd55109;
            5'd5:  v = 17'd52773;
            5'd6:  v = 17'd50535;
            5'd7:  v = 17'd48393;
            5'd8:  v = 17'd46341;
            5'd9:  v = 17'd44376;
            5'd10: v = 17'd42495;
            5'd11: v = 17'd40693;
            5'd12: v = 17'd38968;
            5'd13: v = 17'd37316;
            5'd14: v = 17'd35734;
            5'd15: v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction
endpackage

// ----- rtl/rse_divider.sv -----
// Restoring divider: (e << 16 + sum/2) / sum, saturated to 16 bits.
module rse_divider
    import rse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [15:0]      e,
    input  logic [SUM_W-1:0] sum,
    output logic             done,
    output logic [15:0]      quot
);
    localparam int NUM_W = 33;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [SUM_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SUM_W-1:0] d_reg, d_next;
    logic [SUM_W:0]   trial;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        d_next    = d_reg;
        done_next = 1'b0;
        trial     = {rem_reg[SUM_W-1:0], num_reg[NUM_W-1]};
        if (start)
        begin
            num_next  = {1'b0, e, 16'd0} + {11'd0, sum[SUM_W-1:1]};
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = 6'(NUM_W);
            busy_next = 1'b1;
            d_next    = sum;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = trial - {1'b0, d_reg};
                q_next   = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign done = done_reg;
    assign quot = (d_reg == '0 || q_reg[NUM_W-1:16] != '0) ? 16'hFFFF : q_reg[15:0];
endmodule

// ----- rtl/row_softmax_engine_top.sv -----
// Top level of the row softmax engine.
// Usage:
//  in channel: one logit per transaction (in_valid/in_stall), row_end on the last.
//  out channel: one transaction per stored element after row_end, in order,
//  with elem_index, last_out and truncated (row had elements dropped).
//  Load: one cycle per element, written to a 64-entry one-read one-write row memory.
//  Exponential pass: per element, in order, a memory read, a log2(e) multiply,
//  then table interpolation and accumulate into the 23-bit sum.
//  Normalize pass: per element a memory read then a bit-serial divide; each
//  result then waits in the output register until the receiver takes it.
//  Exponentials are written back over the stored logits in the same memory.
//  in_stall is high from row_end until the last result is taken.
//  Reset clears the maximum, count, sum and overflow flag; the row memory
//  is not cleared, only entries written in the current row are read.
//  A stalled result holds steady; the engine waits on it.
`include "assert_macros.svh"
module row_softmax_engine_top
    import rse_pkg::*;
#(
    parameter int MAX_ROW = MAX_ROW_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  rse_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output rse_out_t out_data
);
    localparam int CAP = (MAX_ROW < 1) ? 1 : ((MAX_ROW > STORE_DEPTH) ? STORE_DEPTH : MAX_ROW);

    logic [15:0] mem [STORE_DEPTH];
    logic [15:0] rd_data_reg;
    logic        wr_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [15:0] wr_data;

    rse_state_t st_reg, st_next;
    logic signed [15:0] max_reg, max_next;
    logic [IDX_W:0]     cnt_reg, cnt_next;
    logic [IDX_W:0]     ptr_reg, ptr_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               ovf_reg, ovf_next;
    logic               ov_reg, ov_next;
    rse_out_t           od_reg, od_next;

    logic               in_acc, keep;
    logic [16:0]        dlt;
    logic [33:0]        tprod_reg, tprod_next;
    logic [16:0]        tk, tk1, vint;
    logic [28:0]        prod;
    logic [15:0]        e_val;
    logic [9:0]         nsh;
    logic               div_done;
    logic [15:0]        div_q;

    assign in_acc = in_valid && !in_stall;
    assign keep   = cnt_reg < (IDX_W+1)'(CAP);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        dlt        = 17'(max_reg) - 17'(signed'(rd_data_reg));
        tprod_next = 34'(dlt) * 34'(LOG2E_Q16);
    end

    always_ff @(posedge clk)
    begin
        tprod_reg <= tprod_next;
    end

    always_comb
    begin
        nsh   = tprod_reg[33:24];
        tk    = pow2_tab({1'b0, tprod_reg[23:20]});
        tk1   = pow2_tab(5'({1'b0, tprod_reg[23:20]}) + 5'd1);
        prod  = 29'(tk - tk1) * 29'(tprod_reg[19:8]) + 29'd2048;
        vint  = tk - 17'(prod[28:12]);
        if (nsh >= 10'd17)
            e_val = '0;
        else if (nsh == 10'd0)
            e_val = (vint > 17'd65535) ? 16'hFFFF : vint[15:0];
        else
            e_val = 16'((vint + (17'd1 << (nsh[4:0] - 5'd1))) >> nsh[4:0]);
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_LOAD:     if (in_acc && in_data.row_end) st_next = ST_EXP_RD;
            ST_EXP_RD:   st_next = ST_EXP_WAIT;
            ST_EXP_WAIT: st_next = ST_EXP_ACC;
            ST_EXP_ACC:  st_next = (ptr_reg + 1'b1 == cnt_reg) ? ST_NRM_RD : ST_EXP_RD;
            ST_NRM_RD:   st_next = ST_NRM_DIV;
            ST_NRM_DIV:  if (div_done) st_next = ST_NRM_OUT;
            ST_NRM_OUT:
                if (!ov_reg || !out_stall)
                    st_next = ov_reg ? ST_NRM_OUT : ST_NRM_OUT;
            default:     st_next = ST_LOAD;
        endcase
        if (st_reg == ST_NRM_OUT && ov_reg && !out_stall)
            st_next = od_reg.last_out ? ST_LOAD : ST_NRM_RD;
    end

    always_comb
    begin
        max_next  = max_reg;
        cnt_next  = cnt_reg;
        ptr_next  = ptr_reg;
        sum_next  = sum_reg;
        ovf_next  = ovf_reg;
        ov_next   = ov_reg;
        od_next   = od_reg;
        wr_en     = 1'b0;
        wr_addr   = cnt_reg[IDX_W-1:0];
        wr_data   = in_data.logit;
        rd_addr   = ptr_reg[IDX_W-1:0];
        in_stall  = (st_reg != ST_LOAD);
        unique case (st_reg)
            ST_LOAD:
                if (in_acc)
                begin
                    if (keep)
                    begin
                        wr_en    = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                        if (in_data.logit > max_reg)
                            max_next = in_data.logit;
                    end
                    else
                        ovf_next = 1'b1;
                    ptr_next = '0;
                    sum_next = '0;
                end
            ST_EXP_ACC:
            begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[IDX_W-1:0];
                wr_data  = e_val;
                sum_next = sum_reg + SUM_W'(e_val);
                ptr_next = (ptr_reg + 1'b1 == cnt_reg) ? '0 : ptr_reg + 1'b1;
            end
            ST_NRM_OUT:
            begin
                if (!ov_reg)
                begin
                    ov_next            = 1'b1;
                    od_next.prob       = div_q;
                    od_next.elem_index = ptr_reg[IDX_W-1:0];
                    od_next.last_out   = (ptr_reg + 1'b1 == cnt_reg);
                    od_next.truncated  = ovf_reg;
                end
                else if (!out_stall)
                begin
                    ov_next  = 1'b0;
                    ptr_next = ptr_reg + 1'b1;
                    if (od_reg.last_out)
                    begin
                        max_next = 16'sh8000;
                        cnt_next = '0;
                        sum_next = '0;
                        ovf_next = 1'b0;
                        ptr_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    logic dstart_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dstart_reg <= 1'b0;
        else
            dstart_reg <= (st_reg == ST_NRM_RD);
    end

    rse_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart_reg),
        .e     (rd_data_reg),
        .sum   (sum_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_LOAD;
            max_reg <= 16'sh8000;
            cnt_reg <= '0;
            ptr_reg <= '0;
            sum_reg <= '0;
            ovf_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            max_reg <= max_next;
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
            sum_reg <= sum_next;
            ovf_reg <= ovf_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    `ASSERT_IMPL(a_cnt_cap, clk, rst_n, 1'b1, cnt_reg <= (IDX_W+1)'(CAP), "count over capacity")
    `ASSERT_IMPL(a_valid_state, clk, rst_n, ov_reg, st_reg == ST_NRM_OUT, "result outside output state")
    `ASSERT_NEXT(a_last_clear, clk, rst_n, ov_reg && !out_stall && od_reg.last_out, cnt_reg == '0 && st_reg == ST_LOAD, "row state not cleared")
endmodule
